// File: sv/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared control structs and fixed field widths.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int CFG_W       = 4;
    localparam int PORT_PAGE_W = 16;
    localparam int PORT_SLOT_W = 3;
    localparam int FAULT_W     = 32;

    localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd3;
    localparam logic [FAULT_W-1:0] FAULT_SAT    = '1;

    // flags of the scan record that travels down the cell chain
    typedef struct packed {
        logic found;
        logic empty;
    } lrupr_scan_t;

    // update broadcast from the sequencer to every cell
    typedef struct packed {
        logic commit;
        logic hit;
    } lrupr_upd_t;

endpackage

// File: sv/lrupr_cell.sv
// ----------------------------------------------------------------------------
// LRU page replacement frame cell
// Holds one frame (page, valid, recency rank), folds its frame into the scan
// record handed down the chain and applies the recency update on commit.
// ----------------------------------------------------------------------------
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int SLOT_W     = 3,
    parameter int RANK_W     = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 active,
    input  logic [PAGE_BITS-1:0] ref_page,
    input  logic                 step_in,
    input  lrupr_scan_t          flags_in,
    input  logic [SLOT_W-1:0]    found_slot_in,
    input  logic [RANK_W-1:0]    hit_rank_in,
    input  logic [SLOT_W-1:0]    empty_slot_in,
    input  logic [RANK_W-1:0]    best_rank_in,
    input  logic [SLOT_W-1:0]    best_slot_in,
    input  logic [PAGE_BITS-1:0] best_page_in,
    output logic                 step_out,
    output lrupr_scan_t          flags_out,
    output logic [SLOT_W-1:0]    found_slot_out,
    output logic [RANK_W-1:0]    hit_rank_out,
    output logic [SLOT_W-1:0]    empty_slot_out,
    output logic [RANK_W-1:0]    best_rank_out,
    output logic [SLOT_W-1:0]    best_slot_out,
    output logic [PAGE_BITS-1:0] best_page_out,
    input  lrupr_upd_t           upd,
    input  logic [SLOT_W-1:0]    upd_slot,
    input  logic [RANK_W:0]      upd_limit
);

    localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(IDX);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);
    localparam bit                FIRST    = (IDX == 0);

    logic                 valid_reg, valid_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 step_reg;
    lrupr_scan_t          flags_reg, flags_next;
    logic [SLOT_W-1:0]    found_slot_reg, found_slot_next;
    logic [RANK_W-1:0]    hit_rank_reg, hit_rank_next;
    logic [SLOT_W-1:0]    empty_slot_reg, empty_slot_next;
    logic [RANK_W-1:0]    best_rank_reg, best_rank_next;
    logic [SLOT_W-1:0]    best_slot_reg, best_slot_next;
    logic [PAGE_BITS-1:0] best_page_reg, best_page_next;
    logic                 match;
    logic                 take_best;

    // fold this frame into the scan record
    always_comb
    begin
        match     = active && valid_reg && (page_reg == ref_page);
        take_best = active && (FIRST || (rank_reg > best_rank_in));

        flags_next      = flags_in;
        found_slot_next = found_slot_in;
        hit_rank_next   = hit_rank_in;
        empty_slot_next = empty_slot_in;
        best_rank_next  = best_rank_in;
        best_slot_next  = best_slot_in;
        best_page_next  = best_page_in;

        if (match && !flags_in.found)
        begin
            flags_next.found = 1'b1;
            found_slot_next  = MY_SLOT;
            hit_rank_next    = rank_reg;
        end
        if (active && !valid_reg && !flags_in.empty)
        begin
            flags_next.empty = 1'b1;
            empty_slot_next  = MY_SLOT;
        end
        if (take_best)
        begin
            best_rank_next = rank_reg;
            best_slot_next = MY_SLOT;
            best_page_next = page_reg;
        end
    end

    // recency update on commit
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        page_next  = page_reg;
        if (upd.commit)
        begin
            if (MY_SLOT == upd_slot)
            begin
                rank_next = '0;
                if (!upd.hit)
                begin
                    valid_next = 1'b1;
                    page_next  = ref_page;
                end
            end
            else if (active && valid_reg && ({1'b0, rank_reg} < upd_limit)
                     && (rank_reg != RANK_MAX))
            begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            step_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            step_reg  <= step_in;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        flags_reg      <= flags_next;
        found_slot_reg <= found_slot_next;
        hit_rank_reg   <= hit_rank_next;
        empty_slot_reg <= empty_slot_next;
        best_rank_reg  <= best_rank_next;
        best_slot_reg  <= best_slot_next;
        best_page_reg  <= best_page_next;
    end

    assign step_out       = step_reg;
    assign flags_out      = flags_reg;
    assign found_slot_out = found_slot_reg;
    assign hit_rank_out   = hit_rank_reg;
    assign empty_slot_out = empty_slot_reg;
    assign best_rank_out  = best_rank_reg;
    assign best_slot_out  = best_slot_reg;
    assign best_page_out  = best_page_reg;

endmodule

// File: sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement
// Keeps up to MAX_FRAMES resident pages in a chain of frame cells, each holding
// a recency rank; each page reference yields hit or fault, the frame used, any
// evicted page and a saturating fault total.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   page_number
//  out      source     out_valid / out_stall hit, frame_slot, evicted_valid,
//                                            evicted_page, fault_total
//  cfg      sink       cfg_valid / cfg_ready cfg_data (frames_in_use)
//
//  Per item, a scan record walks the frame cells, registered in each cell in
//  turn, then the chosen frame is registered and the commit writes it out.
//  An output stall holds the commit; the next beat is taken while a result
//  waits in the output register. Reset clears valid bits, ranks and the
//  fault total; cfg_ready is always high.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PORT_PAGE_W-1:0] page_number,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic [PORT_SLOT_W-1:0] frame_slot,
    output logic                   evicted_valid,
    output logic [PORT_PAGE_W-1:0] evicted_page,
    output logic [FAULT_W-1:0]     fault_total,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W = SLOT_W;
    localparam logic [RANK_W:0] LIMIT_ALL = (RANK_W + 1)'(MAX_FRAMES);
    localparam logic [7:0]      NMAX      = 8'(MAX_FRAMES);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       frames_reg;
    logic                   start_reg;
    logic [PAGE_BITS-1:0]   page_reg;
    logic                   hit_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [RANK_W:0]        limit_reg;
    logic                   evict_reg;
    logic [PAGE_BITS-1:0]   evpage_reg;
    logic [FAULT_W-1:0]     fault_reg, fault_next;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [PORT_SLOT_W-1:0] out_slot_reg;
    logic                   out_evict_reg;
    logic [PORT_PAGE_W-1:0] out_evpage_reg;
    logic [FAULT_W-1:0]     out_fault_reg;

    logic                           in_accept;
    logic                           out_free;
    logic                           scan_done;
    logic [7:0]                     n_active;
    logic [MAX_FRAMES-1:0]          active;
    logic [PAGE_BITS+PORT_PAGE_W-1:0] page_in_ext;
    logic [PAGE_BITS+PORT_PAGE_W-1:0] evpage_ext;
    logic [SLOT_W+PORT_SLOT_W-1:0]  slot_ext;
    lrupr_upd_t                     upd;

    logic                 ch_step       [MAX_FRAMES+1];
    lrupr_scan_t          ch_flags      [MAX_FRAMES+1];
    logic [SLOT_W-1:0]    ch_found_slot [MAX_FRAMES+1];
    logic [RANK_W-1:0]    ch_hit_rank   [MAX_FRAMES+1];
    logic [SLOT_W-1:0]    ch_empty_slot [MAX_FRAMES+1];
    logic [RANK_W-1:0]    ch_best_rank  [MAX_FRAMES+1];
    logic [SLOT_W-1:0]    ch_best_slot  [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0] ch_best_page  [MAX_FRAMES+1];

    assign in_accept   = in_valid && !in_stall;
    assign in_stall    = (state_reg != ST_IDLE);
    assign out_free    = !out_valid_reg || !out_stall;
    assign scan_done   = ch_step[MAX_FRAMES];
    assign cfg_ready   = 1'b1;
    assign page_in_ext = {{PAGE_BITS{1'b0}}, page_number};
    assign evpage_ext  = {{PORT_PAGE_W{1'b0}}, evpage_reg};
    assign slot_ext    = {{PORT_SLOT_W{1'b0}}, slot_reg};

    // clamp the frame count to 1 .. MAX_FRAMES
    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_active = 8'd1;
        end
        else if ({4'd0, frames_reg} > NMAX)
        begin
            n_active = NMAX;
        end
        else
        begin
            n_active = {4'd0, frames_reg};
        end
    end

    // seed record
    assign ch_step[0]       = start_reg;
    assign ch_flags[0]      = '0;
    assign ch_found_slot[0] = '0;
    assign ch_hit_rank[0]   = '0;
    assign ch_empty_slot[0] = '0;
    assign ch_best_rank[0]  = '0;
    assign ch_best_slot[0]  = '0;
    assign ch_best_page[0]  = '0;

    assign upd.commit = (state_reg == ST_COMMIT) && out_free;
    assign upd.hit    = hit_reg;

    for (genvar g = 0; g < MAX_FRAMES; g++)
    begin : g_cell
        assign active[g] = (8'(g) < n_active);

        lrupr_cell #(
            .IDX        (g),
            .MAX_FRAMES (MAX_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .SLOT_W     (SLOT_W),
            .RANK_W     (RANK_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .active         (active[g]),
            .ref_page       (page_reg),
            .step_in        (ch_step[g]),
            .flags_in       (ch_flags[g]),
            .found_slot_in  (ch_found_slot[g]),
            .hit_rank_in    (ch_hit_rank[g]),
            .empty_slot_in  (ch_empty_slot[g]),
            .best_rank_in   (ch_best_rank[g]),
            .best_slot_in   (ch_best_slot[g]),
            .best_page_in   (ch_best_page[g]),
            .step_out       (ch_step[g+1]),
            .flags_out      (ch_flags[g+1]),
            .found_slot_out (ch_found_slot[g+1]),
            .hit_rank_out   (ch_hit_rank[g+1]),
            .empty_slot_out (ch_empty_slot[g+1]),
            .best_rank_out  (ch_best_rank[g+1]),
            .best_slot_out  (ch_best_slot[g+1]),
            .best_page_out  (ch_best_page[g+1]),
            .upd            (upd),
            .upd_slot       (slot_reg),
            .upd_limit      (limit_reg)
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fault_next = fault_reg;
        if (upd.commit && !hit_reg && (fault_reg != FAULT_SAT))
        begin
            fault_next = fault_reg + FAULT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frames_reg    <= FRAMES_RESET;
            start_reg     <= 1'b0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_accept;
            fault_reg <= fault_next;
            if (cfg_valid && cfg_ready)
            begin
                frames_reg <= cfg_data;
            end
            if (upd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            page_reg <= page_in_ext[PAGE_BITS-1:0];
        end
        if ((state_reg == ST_SCAN) && scan_done)
        begin
            hit_reg   <= ch_flags[MAX_FRAMES].found;
            evict_reg <= !ch_flags[MAX_FRAMES].found && !ch_flags[MAX_FRAMES].empty;
            if (ch_flags[MAX_FRAMES].found)
            begin
                slot_reg   <= ch_found_slot[MAX_FRAMES];
                limit_reg  <= {1'b0, ch_hit_rank[MAX_FRAMES]};
                evpage_reg <= '0;
            end
            else if (ch_flags[MAX_FRAMES].empty)
            begin
                slot_reg   <= ch_empty_slot[MAX_FRAMES];
                limit_reg  <= LIMIT_ALL;
                evpage_reg <= '0;
            end
            else
            begin
                slot_reg   <= ch_best_slot[MAX_FRAMES];
                limit_reg  <= LIMIT_ALL;
                evpage_reg <= ch_best_page[MAX_FRAMES];
            end
        end
        if (upd.commit)
        begin
            out_hit_reg    <= hit_reg;
            out_slot_reg   <= slot_ext[PORT_SLOT_W-1:0];
            out_evict_reg  <= evict_reg;
            out_evpage_reg <= evpage_ext[PORT_PAGE_W-1:0];
            out_fault_reg  <= fault_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign frame_slot    = out_slot_reg;
    assign evicted_valid = out_evict_reg;
    assign evicted_page  = out_evpage_reg;
    assign fault_total   = out_fault_reg;

endmodule

// File: sv/lrupr_checker.sv
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level properties of the replacement block, bound to the top level.
// ----------------------------------------------------------------------------
module lrupr_checker
    import lrupr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   hit,
    input logic [PORT_SLOT_W-1:0] frame_slot,
    input logic                   evicted_valid,
    input logic [PORT_PAGE_W-1:0] evicted_page,
    input logic [FAULT_W-1:0]     fault_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(frame_slot)
            && $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_total))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while busy");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted_valid)
        else $error("hit reports an eviction");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0)
        else $error("evicted page not zero without eviction");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> fault_total != '0)
        else $error("fault with zero fault total");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .frame_slot    (frame_slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
);

// File: tb/tb_lru_page_replacement.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Streams page references through the block under bursty input traffic and
// a varying output stall, predicts every result with an independent LRU
// tracker, and checks each result beat field by field. The frame count is
// rewritten between phases, including out-of-range and shrink/grow settings.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int FRAMES        = 8;
    localparam int AGE_MAX       = FRAMES - 1;
    localparam int SETTLE_CYCLES = 2 * (FRAMES + 3);
    localparam int DRAIN_GUARD   = 4000;
    localparam int PHASE_ITEMS   = 140;
    localparam int RANDOM_PHASES = 10;

    typedef struct packed {
        logic                   hit;
        logic [PORT_SLOT_W-1:0] slot;
        logic                   ev_valid;
        logic [PORT_PAGE_W-1:0] ev_page;
        logic [FAULT_W-1:0]     faults;
    } page_access_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic [PORT_PAGE_W-1:0] page_number   = '0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic                   hit;
    logic [PORT_SLOT_W-1:0] frame_slot;
    logic                   evicted_valid;
    logic [PORT_PAGE_W-1:0] evicted_page;
    logic [FAULT_W-1:0]     fault_total;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data      = '0;

    // LRU tracker state
    logic [PORT_PAGE_W-1:0] frame_page [FRAMES];
    bit                     frame_used [FRAMES];
    int unsigned            frame_age  [FRAMES];
    logic [FAULT_W-1:0]     fault_tally;
    logic [CFG_W-1:0]       frames_setting;

    logic [PORT_PAGE_W-1:0] pending_pages [$];
    page_access_t           expected_results [$];
    page_access_t           want;

    int          failures      = 0;
    int          refs_sent     = 0;
    int          hits_seen     = 0;
    int          results_seen  = 0;
    int          setting_count = 0;
    int          burst_left    = 0;
    int          gap_left      = 0;
    int          mode_left     = 0;
    stall_mode_t stall_mode    = STALL_NONE;

    lru_page_replacement #(
        .MAX_FRAMES (FRAMES),
        .PAGE_BITS  (PORT_PAGE_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void enqueue_page(logic [PORT_PAGE_W-1:0] page);
        pending_pages = {pending_pages, page};
    endfunction

    function automatic void enqueue_result(page_access_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic int active_count(logic [CFG_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > FRAMES)
            return FRAMES;
        return int'(setting);
    endfunction

    function automatic void age_frames(int n, int s, int unsigned limit);
        for (int i = 0; i < n; i++)
            if (i != s && frame_used[i] && frame_age[i] < limit && frame_age[i] < AGE_MAX)
                frame_age[i]++;
        frame_age[s] = 0;
    endfunction

    function automatic page_access_t lookup_page(logic [PORT_PAGE_W-1:0] page);
        page_access_t r;
        int           n;
        int           slot;
        bit           found;
        bit           empty;
        int unsigned  oldest;
        r     = '0;
        n     = active_count(frames_setting);
        slot  = 0;
        found = 1'b0;
        empty = 1'b0;
        for (int i = 0; i < n; i++)
            if (!found && frame_used[i] && frame_page[i] == page)
            begin
                slot  = i;
                found = 1'b1;
            end
        if (found)
        begin
            r.hit = 1'b1;
            age_frames(n, slot, frame_age[slot]);
        end
        else
        begin
            if (fault_tally != FAULT_SAT)
                fault_tally++;
            for (int i = 0; i < n; i++)
                if (!empty && !frame_used[i])
                begin
                    slot  = i;
                    empty = 1'b1;
                end
            if (!empty)
            begin
                oldest = 0;
                slot   = 0;
                for (int i = 0; i < n; i++)
                    if (frame_age[i] > oldest)
                    begin
                        oldest = frame_age[i];
                        slot   = i;
                    end
                r.ev_valid = 1'b1;
                r.ev_page  = frame_page[slot];
            end
            frame_page[slot] = page;
            frame_used[slot] = 1'b1;
            age_frames(n, slot, AGE_MAX + 1);
        end
        r.slot   = slot[PORT_SLOT_W-1:0];
        r.faults = fault_tally;
        return r;
    endfunction

    // Driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            page_number <= '0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                void'(pending_pages.pop_front());
                enqueue_result(lookup_page(page_number));
                refs_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_pages.size() > 0)
                begin
                    in_valid    <= 1'b1;
                    page_number <= pending_pages[0];
                    burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat and drive the output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode = STALL_NONE;
            mode_left  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no reference outstanding");
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.hit)
                        hits_seen++;
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        failures++;
                    end
                    if (frame_slot !== want.slot)
                    begin
                        $error("frame_slot: expected %0d, got %0d", want.slot, frame_slot);
                        failures++;
                    end
                    if (evicted_valid !== want.ev_valid)
                    begin
                        $error("evicted_valid: expected %0d, got %0d",
                               want.ev_valid, evicted_valid);
                        failures++;
                    end
                    if (evicted_page !== want.ev_page)
                    begin
                        $error("evicted_page: expected 0x%04h, got 0x%04h",
                               want.ev_page, evicted_page);
                        failures++;
                    end
                    if (fault_total !== want.faults)
                    begin
                        $error("fault_total: expected %0d, got %0d", want.faults, fault_total);
                        failures++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= (mode_left % 8) < 3;
            endcase
        end
    end

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (pending_pages.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_results.size() != 0)
        begin
            $error("drain: %0d results never arrived", expected_results.size());
            failures++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frames(logic [CFG_W-1:0] setting);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= setting;
        do
            @(posedge clk);
        while (!cfg_ready);
        frames_setting = setting;
        setting_count++;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_workload(int count, int span);
        logic [PORT_PAGE_W-1:0] pool [16];
        int                     ws;
        int                     pick;
        ws = $urandom_range(1, span + 3);
        for (int i = 0; i < 16; i++)
            pool[i] = ($urandom_range(0, 1) == 0) ? PORT_PAGE_W'($urandom_range(0, 31))
                                                  : PORT_PAGE_W'($urandom);
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                enqueue_page(PORT_PAGE_W'($urandom));
            else if (pick < 9)
                enqueue_page(($urandom_range(0, 1) == 0) ? PORT_PAGE_W'(0)
                                                         : {PORT_PAGE_W{1'b1}});
            else
            begin
                // drift the working set now and then
                if (pick < 13)
                    pool[$urandom_range(0, ws - 1)] = PORT_PAGE_W'($urandom);
                enqueue_page(pool[$urandom_range(0, ws - 1)]);
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] settings [RANDOM_PHASES];
        settings = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6};
        settings[8] = CFG_W'($urandom_range(0, 15));
        settings[9] = CFG_W'($urandom_range(9, 15));

        frames_setting = FRAMES_RESET;
        fault_tally    = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            frame_page[i] = '0;
            frame_used[i] = 1'b0;
            frame_age[i]  = 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset frame count: fill, hit, evict
        pending_pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'h8000,
                          16'hFFFF, 16'h0001, 16'h1234};
        wait_idle();
        set_frames(4'd8);
        pending_pages = '{16'h00AA, 16'h0055, 16'h5555, 16'hAAAA, 16'h0F0F, 16'h5555};
        wait_idle();
        // shrink so resident pages drop out of range, then grow to expose duplicates
        set_frames(4'd2);
        pending_pages = '{16'h5555, 16'h7777, 16'h0F0F};
        wait_idle();
        set_frames(4'd8);
        pending_pages = '{16'h5555, 16'h0F0F, 16'h3C3C};
        wait_idle();
        set_frames(4'd0);
        pending_pages = '{16'h4321, 16'h4321, 16'h9999};
        wait_idle();
        set_frames(4'd15);
        pending_pages = '{16'h4321, 16'h00AA, 16'hFFFF};
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_frames(settings[p]);
            queue_workload(PHASE_ITEMS, active_count(settings[p]));
            wait_idle();
        end

        $display("Run covered %0d page references: %0d hits, %0d faults, %0d results checked",
                 refs_sent, hits_seen, fault_tally, results_seen);
        $display("Frame count rewritten %0d times, including 0, 1, 8 and 15", setting_count);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
sv/lrupr_pkg.sv
sv/lrupr_cell.sv
sv/lru_page_replacement.sv
sv/lrupr_checker.sv
tb/tb_lru_page_replacement.sv
